@@ rtl/core/aligned_stack_allocator_assert.svh @@
// Assertion helpers shared by the allocator RTL.
// Each macro expects clk_i and rst_ni in scope and is placed on a line of its own.
`ifndef ALIGNED_STACK_ALLOCATOR_ASSERT_SVH
`define ALIGNED_STACK_ALLOCATOR_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define ASA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ rtl/core/asa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package asa_pkg;

  // Allocator sizing.
  localparam int unsigned HeaderBytes  = 4;
  localparam int unsigned MaxLive      = 16;
  localparam int unsigned OffsetBits   = 24;
  localparam int unsigned MaxAlignLog2 = 12;

  // Derived widths.
  localparam int unsigned IdxW   = $clog2(MaxLive);
  localparam int unsigned DepthW = $clog2(MaxLive + 1);
  localparam int unsigned OffW   = 25;
  localparam int unsigned EndW   = OffW + 1;
  localparam int unsigned AdjW   = MaxAlignLog2 + 1;

  // Largest usable region size.
  localparam logic [OffW-1:0] CapLimit = OffW'(1) << OffsetBits;

  // Item kinds.
  localparam logic [1:0] KindAlloc   = 2'd0;
  localparam logic [1:0] KindDealloc = 2'd1;
  localparam logic [1:0] KindMarker  = 2'd2;
  localparam logic [1:0] KindReset   = 2'd3;

  // Result status codes.
  localparam logic [2:0] StatusOk      = 3'd0;
  localparam logic [2:0] StatusBad     = 3'd1;
  localparam logic [2:0] StatusSpace   = 3'd2;
  localparam logic [2:0] StatusFull    = 3'd3;
  localparam logic [2:0] StatusNotLive = 3'd4;

  // Configuration register indexes.
  localparam logic CfgBase = 1'b0;
  localparam logic CfgCap  = 1'b1;

  typedef struct packed {
    logic [1:0]      kind;
    logic [OffW-1:0] alloc_size;
    logic [3:0]      align_log2;
    logic [31:0]     pointer;
    logic [OffW-1:0] marker;
  } asa_in_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [31:0]     address;
    logic [OffW-1:0] used_bytes;
    logic [OffW-1:0] peak_bytes;
    logic [31:0]     live_count;
    logic [31:0]     total_count;
  } asa_out_t;

  // Region settings as seen by the sequencer.
  typedef struct packed {
    logic [31:0]     base;
    logic [OffW-1:0] cap;
    logic [OffW-1:0] cap_eff;
  } asa_cfg_t;

  // One record: block start offset and returned offset.
  typedef struct packed {
    logic [OffW-1:0] start;
    logic [OffW-1:0] result;
  } asa_rec_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic        cin;
  } asa_alu_req_t;

  typedef struct packed {
    logic [31:0] sum;
    logic        cout;
  } asa_alu_rsp_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    asa_rec_t        wdata;
    logic            re;
    logic [IdxW-1:0] raddr;
  } asa_rec_cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/asa_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Shared 32-bit adder with carry in and carry out; subtracts and compares
// are done by the sequencer through inverted operands and carry in.
module asa_alu import asa_pkg::*; (
  input  asa_alu_req_t req_i,
  output asa_alu_rsp_t rsp_o
);

  logic [32:0] sum;

  // Carry-extended sum.
  assign sum = 33'(req_i.a) + 33'(req_i.b) + 33'(req_i.cin);
  assign rsp_o.sum  = sum[31:0];
  assign rsp_o.cout = sum[32];

endmodule

`default_nettype wire

@@ rtl/core/asa_rec_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Record stack storage: one write port, one registered read port.
module asa_rec_store import asa_pkg::*; (
  input  logic         clk_i,
  input  asa_rec_cmd_t cmd_i,
  output asa_rec_t     rdata_o
);

  asa_rec_t mem [MaxLive];
  asa_rec_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem[cmd_i.waddr] <= cmd_i.wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.re) begin
      rdata_q <= mem[cmd_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/asa_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "aligned_stack_allocator_assert.svh"

// Sequencer: holds the allocator state and steps each item through the
// shared adder and the record stack.
module asa_ctrl import asa_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         clear_i,
  input  asa_cfg_t     cfg_i,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  asa_in_t      in_data_i,
  output logic         res_valid_o,
  input  logic         res_ready_i,
  output asa_out_t     res_data_o,
  output asa_alu_req_t alu_req_o,
  input  asa_alu_rsp_t alu_rsp_i,
  output asa_rec_cmd_t rec_cmd_o,
  input  asa_rec_t     rec_rdata_i
);

  localparam logic [4:0] StIdle   = 5'd0;
  localparam logic [4:0] StABase  = 5'd1;
  localparam logic [4:0] StAAdj   = 5'd2;
  localparam logic [4:0] StARes   = 5'd3;
  localparam logic [4:0] StAEnd   = 5'd4;
  localparam logic [4:0] StACmp   = 5'd5;
  localparam logic [4:0] StAAddr  = 5'd6;
  localparam logic [4:0] StAPeak  = 5'd7;
  localparam logic [4:0] StALive  = 5'd8;
  localparam logic [4:0] StATotal = 5'd9;
  localparam logic [4:0] StDRead  = 5'd10;
  localparam logic [4:0] StDChk   = 5'd11;
  localparam logic [4:0] StDLive  = 5'd12;
  localparam logic [4:0] StMCmp   = 5'd13;
  localparam logic [4:0] StMRead  = 5'd14;
  localparam logic [4:0] StMChk   = 5'd15;
  localparam logic [4:0] StDone   = 5'd16;

  logic [4:0]        state_q, state_d;
  logic [OffW-1:0]   top_q, top_d;
  logic [OffW-1:0]   peak_q, peak_d;
  logic [31:0]       live_q, live_d;
  logic [31:0]       total_q, total_d;
  logic [DepthW-1:0] depth_q, depth_d;

  logic [OffW-1:0]   size_q, size_d;
  logic [3:0]        alog_q, alog_d;
  logic [31:0]       ptr_q, ptr_d;
  logic [OffW-1:0]   mark_q, mark_d;
  logic [AdjW-1:0]   adj_q, adj_d;
  logic [OffW-1:0]   res_q, res_d;
  logic [EndW-1:0]   end_q, end_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [2:0]        status_q, status_d;
  logic [31:0]       addr_q, addr_d;

  logic              in_accept;
  logic              bad_req;
  logic [AdjW-1:0]   align;
  logic [AdjW-1:0]   align_mask;
  logic [DepthW-1:0] depth_m1;

  assign in_ready_o  = (state_q == StIdle);
  assign in_accept   = in_valid_i && in_ready_o;
  assign res_valid_o = (state_q == StDone);
  assign align       = AdjW'(1) << alog_q;
  assign align_mask  = align - AdjW'(1);
  assign depth_m1    = depth_q - DepthW'(1);

  // Requests that are rejected without any arithmetic.
  assign bad_req = (cfg_i.cap == '0) || (cfg_i.base == '0) ||
                   (in_data_i.alloc_size == '0) ||
                   (in_data_i.align_log2 > 4'(MaxAlignLog2));

  // Sequencer and datapath steering.
  always_comb begin
    state_d   = state_q;
    top_d     = top_q;
    peak_d    = peak_q;
    live_d    = live_q;
    total_d   = total_q;
    depth_d   = depth_q;
    size_d    = size_q;
    alog_d    = alog_q;
    ptr_d     = ptr_q;
    mark_d    = mark_q;
    adj_d     = adj_q;
    res_d     = res_q;
    end_d     = end_q;
    idx_d     = idx_q;
    status_d  = status_q;
    addr_d    = addr_q;
    alu_req_o = '0;
    rec_cmd_o = '0;

    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          size_d   = in_data_i.alloc_size;
          alog_d   = in_data_i.align_log2;
          ptr_d    = in_data_i.pointer;
          mark_d   = in_data_i.marker;
          addr_d   = '0;
          status_d = StatusOk;
          unique case (in_data_i.kind)
            KindAlloc: begin
              if (bad_req) begin
                status_d = StatusBad;
                state_d  = StDone;
              end else begin
                state_d = StABase;
              end
            end
            KindDealloc: begin
              if (in_data_i.pointer == '0) begin
                state_d = StDone;
              end else if (depth_q == '0) begin
                status_d = StatusNotLive;
                state_d  = StDone;
              end else begin
                idx_d   = depth_m1[IdxW-1:0];
                state_d = StDRead;
              end
            end
            KindMarker: begin
              state_d = StMCmp;
            end
            KindReset: begin
              mark_d  = '0;
              live_d  = '0;
              state_d = StMCmp;
            end
          endcase
        end
      end

      // Absolute address of the top, then the raw alignment gap.
      StABase: begin
        alu_req_o.a = cfg_i.base;
        alu_req_o.b = 32'(top_q);
        adj_d       = (AdjW'(0) - alu_rsp_i.sum[AdjW-1:0]) & align_mask;
        state_d     = StAAdj;
      end

      // Grow the gap in alignment steps until the header fits.
      StAAdj: begin
        if (adj_q < AdjW'(HeaderBytes)) begin
          alu_req_o.a = 32'(adj_q);
          alu_req_o.b = 32'(align);
          adj_d       = alu_rsp_i.sum[AdjW-1:0];
        end else begin
          state_d = StARes;
        end
      end

      StARes: begin
        alu_req_o.a = 32'(top_q);
        alu_req_o.b = 32'(adj_q);
        res_d       = alu_rsp_i.sum[OffW-1:0];
        state_d     = StAEnd;
      end

      StAEnd: begin
        alu_req_o.a = 32'(res_q);
        alu_req_o.b = 32'(size_q);
        end_d       = alu_rsp_i.sum[EndW-1:0];
        state_d     = StACmp;
      end

      // Carry out means the region still covers the new end.
      StACmp: begin
        alu_req_o.a   = 32'(cfg_i.cap_eff);
        alu_req_o.b   = ~(32'(end_q));
        alu_req_o.cin = 1'b1;
        if (!alu_rsp_i.cout) begin
          status_d = StatusSpace;
          state_d  = StDone;
        end else if (depth_q >= DepthW'(MaxLive)) begin
          status_d = StatusFull;
          state_d  = StDone;
        end else begin
          rec_cmd_o.we           = 1'b1;
          rec_cmd_o.waddr        = depth_q[IdxW-1:0];
          rec_cmd_o.wdata.start  = top_q;
          rec_cmd_o.wdata.result = res_q;
          depth_d = depth_q + DepthW'(1);
          top_d   = end_q[OffW-1:0];
          state_d = StAAddr;
        end
      end

      StAAddr: begin
        alu_req_o.a = cfg_i.base;
        alu_req_o.b = 32'(res_q);
        addr_d      = alu_rsp_i.sum;
        state_d     = StAPeak;
      end

      // No carry out means the new top passes the peak.
      StAPeak: begin
        alu_req_o.a   = 32'(peak_q);
        alu_req_o.b   = ~(32'(top_q));
        alu_req_o.cin = 1'b1;
        if (!alu_rsp_i.cout) begin
          peak_d = top_q;
        end
        state_d = StALive;
      end

      // Saturating increments: a carry out means the count is at maximum.
      StALive: begin
        alu_req_o.a   = live_q;
        alu_req_o.cin = 1'b1;
        if (!alu_rsp_i.cout) begin
          live_d = alu_rsp_i.sum;
        end
        state_d = StATotal;
      end

      StATotal: begin
        alu_req_o.a   = total_q;
        alu_req_o.cin = 1'b1;
        if (!alu_rsp_i.cout) begin
          total_d = alu_rsp_i.sum;
        end
        state_d = StDone;
      end

      StDRead: begin
        rec_cmd_o.re    = 1'b1;
        rec_cmd_o.raddr = idx_q;
        state_d         = StDChk;
      end

      // Compare the record's absolute address with the pointer.
      StDChk: begin
        alu_req_o.a = cfg_i.base;
        alu_req_o.b = 32'(rec_rdata_i.result);
        if (alu_rsp_i.sum == ptr_q) begin
          top_d   = rec_rdata_i.start;
          depth_d = DepthW'(idx_q);
          state_d = StDLive;
        end else if (idx_q == '0) begin
          status_d = StatusNotLive;
          state_d  = StDone;
        end else begin
          idx_d   = idx_q - IdxW'(1);
          state_d = StDRead;
        end
      end

      // Decrement that stops at zero.
      StDLive: begin
        if (live_q != '0) begin
          alu_req_o.a = live_q;
          alu_req_o.b = '1;
          live_d      = alu_rsp_i.sum;
        end
        state_d = StDone;
      end

      // Carry out means the marker is not below the top.
      StMCmp: begin
        alu_req_o.a   = 32'(mark_q);
        alu_req_o.b   = ~(32'(top_q));
        alu_req_o.cin = 1'b1;
        if (alu_rsp_i.cout) begin
          state_d = StDone;
        end else begin
          top_d   = mark_q;
          state_d = StMRead;
        end
      end

      StMRead: begin
        if (depth_q == '0) begin
          state_d = StDone;
        end else begin
          rec_cmd_o.re    = 1'b1;
          rec_cmd_o.raddr = depth_m1[IdxW-1:0];
          state_d         = StMChk;
        end
      end

      // Drop the top record while its start is at or above the new top.
      StMChk: begin
        alu_req_o.a   = 32'(rec_rdata_i.start);
        alu_req_o.b   = ~(32'(top_q));
        alu_req_o.cin = 1'b1;
        if (alu_rsp_i.cout) begin
          depth_d = depth_m1;
          state_d = StMRead;
        end else begin
          state_d = StDone;
        end
      end

      StDone: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase

    // A configuration write restarts the allocator.
    if (clear_i) begin
      top_d   = '0;
      peak_d  = '0;
      live_d  = '0;
      total_d = '0;
      depth_d = '0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      top_q   <= '0;
      peak_q  <= '0;
      live_q  <= '0;
      total_q <= '0;
      depth_q <= '0;
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      peak_q  <= peak_d;
      live_q  <= live_d;
      total_q <= total_d;
      depth_q <= depth_d;
    end
  end

  // Working registers of the item in flight.
  always_ff @(posedge clk_i) begin
    size_q   <= size_d;
    alog_q   <= alog_d;
    ptr_q    <= ptr_d;
    mark_q   <= mark_d;
    adj_q    <= adj_d;
    res_q    <= res_d;
    end_q    <= end_d;
    idx_q    <= idx_d;
    status_q <= status_d;
    addr_q   <= addr_d;
  end

  assign res_data_o.status      = status_q;
  assign res_data_o.address     = addr_q;
  assign res_data_o.used_bytes  = top_q;
  assign res_data_o.peak_bytes  = peak_q;
  assign res_data_o.live_count  = live_q;
  assign res_data_o.total_count = total_q;

  `ASA_ASSERT(a_top_in_region, top_q <= cfg_i.cap_eff, "top offset lies beyond the region")
  `ASA_ASSERT(a_peak_covers_top, (state_q == StIdle) |-> (peak_q >= top_q), "peak below top")
  `ASA_NEVER(a_rec_overflow, rec_cmd_o.we && (depth_q >= DepthW'(MaxLive)), "record overflow")
  `ASA_ASSERT(a_fail_no_addr, (res_valid_o && (status_q != StatusOk)) |-> (addr_q == '0), "failed item carries an address")
  `ASA_ASSERT(a_accept_starts, in_accept |=> (state_q != StIdle), "accepted item was not started")

endmodule

`default_nettype wire

@@ rtl/core/aligned_stack_allocator.sv @@
// Channel   Direction  Transfer when           Payload
// in        input      in_valid_i & !in_stall_o   asa_in_t  (kind, size, alignment, pointer, marker)
// out       output     out_valid_o & !out_stall_i asa_out_t (status, address, counts)
// cfg       input      cfg_we_i                   cfg_index_i selects base or capacity
//
// Allocate takes longer when the alignment loop runs; the loop adds one alignment step per
// cycle through the shared adder.
// Deallocate reads and checks records from the top of the stack down until one matches the
// pointer; free-to-marker and reset drop top records while they start at or above the new top.
// Reset clears the region settings and all counts; records need no clearing.
// A waiting result sits in the output register so the next item can transfer in meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module aligned_stack_allocator import asa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  asa_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output asa_out_t out_data_o,
  input  logic     cfg_we_i,
  input  logic     cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0]     base_q, base_d;
  logic [OffW-1:0] cap_q, cap_d;
  logic            out_valid_q, out_valid_d;
  asa_out_t        out_data_q, out_data_d;

  asa_cfg_t     cfg;
  logic         in_ready;
  logic         res_valid;
  logic         res_ready;
  asa_out_t     res_data;
  asa_alu_req_t alu_req;
  asa_alu_rsp_t alu_rsp;
  asa_rec_cmd_t rec_cmd;
  asa_rec_t     rec_rdata;

  // Region registers.
  always_comb begin
    base_d = base_q;
    cap_d  = cap_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgBase: base_d = cfg_data_i;
        CfgCap:  cap_d  = cfg_data_i[OffW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      cap_q  <= '0;
    end else begin
      base_q <= base_d;
      cap_q  <= cap_d;
    end
  end

  // Capacity limited to the offset range.
  assign cfg.base    = base_q;
  assign cfg.cap     = cap_q;
  assign cfg.cap_eff = (cap_q > CapLimit) ? CapLimit : cap_q;

  asa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (cfg_we_i),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data),
    .alu_req_o   (alu_req),
    .alu_rsp_i   (alu_rsp),
    .rec_cmd_o   (rec_cmd),
    .rec_rdata_i (rec_rdata)
  );

  asa_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  asa_rec_store u_rec_store (
    .clk_i   (clk_i),
    .cmd_i   (rec_cmd),
    .rdata_o (rec_rdata)
  );

  assign in_stall_o = !in_ready;

  // Result register: loads when empty or when its result transfers out.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_data_d  = res_data;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

@@ tb/aligned_stack_allocator_check.sv @@
`timescale 1ns / 1ps

module aligned_stack_allocator_check import asa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  asa_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  asa_out_t    out_data_i,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  // Region settings and allocator state as the block should hold them.
  logic [31:0]     region_base;
  logic [OffW-1:0] region_cap;
  logic [OffW-1:0] top_off;
  logic [OffW-1:0] peak_off;
  logic [31:0]     live_allocs;
  logic [31:0]     total_allocs;
  logic [OffW-1:0] rec_start [MaxLive];
  logic [OffW-1:0] rec_ret   [MaxLive];
  int unsigned     rec_depth;

  // Results still owed by the block, oldest first.
  asa_out_t        owed_results[$];
  int              mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic void clear_allocator();
    top_off      = '0;
    peak_off     = '0;
    live_allocs  = '0;
    total_allocs = '0;
    rec_depth    = 0;
  endfunction

  // Lower the top to the mark and drop every record that starts at or above it.
  function automatic void roll_top_back(logic [OffW-1:0] mark);
    if (mark < top_off) begin
      top_off = mark;
      while (rec_depth > 0 && rec_start[rec_depth-1] >= top_off) rec_depth--;
    end
  endfunction

  // Apply one request to the allocator state and return the result it earns.
  function automatic asa_out_t serve_request(asa_in_t req);
    asa_out_t    res;
    logic [63:0] step;
    logic [63:0] misalign;
    logic [63:0] adj;
    logic [63:0] need;
    logic [63:0] ret_off;
    logic [63:0] usable;
    int          hit;
    int          k;
    res = '0;
    res.status = StatusOk;
    case (req.kind)
      KindAlloc: begin
        usable = (region_cap > CapLimit) ? 64'(CapLimit) : 64'(region_cap);
        if (region_cap == '0 || region_base == '0 || req.alloc_size == '0 ||
            req.align_log2 > MaxAlignLog2) begin
          res.status = StatusBad;
        end else begin
          step     = 64'd1 << req.align_log2;
          misalign = (64'(region_base) + 64'(top_off)) & (step - 64'd1);
          adj      = (misalign != 64'd0) ? step - misalign : 64'd0;
          // Grow the adjustment in whole alignment steps until the header fits.
          if (adj < HeaderBytes) begin
            need = HeaderBytes - adj;
            adj  = adj + step * ((need + step - 64'd1) / step);
          end
          ret_off = 64'(top_off) + adj;
          if (ret_off + 64'(req.alloc_size) > usable) begin
            res.status = StatusSpace;
          end else if (rec_depth >= MaxLive) begin
            res.status = StatusFull;
          end else begin
            rec_start[rec_depth] = top_off;
            rec_ret[rec_depth]   = OffW'(ret_off);
            rec_depth++;
            res.address = region_base + 32'(ret_off);
            top_off     = OffW'(ret_off + 64'(req.alloc_size));
            if (top_off > peak_off) peak_off = top_off;
            if (live_allocs != '1) live_allocs++;
            if (total_allocs != '1) total_allocs++;
          end
        end
      end
      KindDealloc: begin
        // A null pointer is accepted and changes nothing.
        if (req.pointer != '0) begin
          hit = -1;
          for (k = int'(rec_depth) - 1; k >= 0 && hit < 0; k--) begin
            if (region_base + 32'(rec_ret[k]) == req.pointer) hit = k;
          end
          if (hit < 0) begin
            res.status = StatusNotLive;
          end else begin
            top_off   = rec_start[hit];
            rec_depth = hit;
            if (live_allocs != '0) live_allocs--;
          end
        end
      end
      KindMarker: begin
        roll_top_back(req.marker);
      end
      KindReset: begin
        roll_top_back('0);
        live_allocs = '0;
      end
      default: begin
      end
    endcase
    res.used_bytes  = top_off;
    res.peak_bytes  = peak_off;
    res.live_count  = live_allocs;
    res.total_count = total_allocs;
    return res;
  endfunction

  function automatic bit field_ok(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    asa_out_t want;
    bit       ok;
    if (!rst_ni) begin
      region_base = '0;
      region_cap  = '0;
      clear_allocator();
      owed_results.delete();
      pending_o <= 0;
    end else begin
      // Results leave in order, so each transfer answers the oldest request.
      if (out_valid_i && !out_stall_i) begin
        if (owed_results.size() == 0) begin
          $display("%0t ns: result transfer, expected none, got %0h", $time, out_data_i);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          ok = 1'b1;
          ok &= field_ok("status", 32'(want.status), 32'(out_data_i.status));
          ok &= field_ok("address", want.address, out_data_i.address);
          ok &= field_ok("used_bytes", 32'(want.used_bytes), 32'(out_data_i.used_bytes));
          ok &= field_ok("peak_bytes", 32'(want.peak_bytes), 32'(out_data_i.peak_bytes));
          ok &= field_ok("live_count", want.live_count, out_data_i.live_count);
          ok &= field_ok("total_count", want.total_count, out_data_i.total_count);
          if (!ok) mismatches++;
        end
      end

      // Either register write starts the region over.
      if (cfg_we_i) begin
        if (cfg_index_i == CfgBase) region_base = cfg_data_i;
        else region_cap = cfg_data_i[OffW-1:0];
        clear_allocator();
      end

      if (in_valid_i && !in_stall_i) owed_results.push_back(serve_request(in_data_i));
      pending_o <= owed_results.size();
    end
  end

endmodule

@@ tb/aligned_stack_allocator_test.sv @@
`timescale 1ns / 1ps

module aligned_stack_allocator_test;
  import asa_pkg::*;

  localparam int HoldCycles = 400;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  asa_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  asa_out_t    out_data;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = CfgBase;
  logic [31:0] cfg_data  = '0;
  int          fail_count;
  int          pending;

  // What the request generator knows of the region and of recent results.
  logic [OffW-1:0] cur_cap    = '0;
  logic [OffW-1:0] last_used  = '0;
  logic [31:0]     seen_ptrs[$];
  int              burst_left = 0;
  bit              hold_req   = 1'b0;
  bit              hold_done  = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  aligned_stack_allocator u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  aligned_stack_allocator_check u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Keep returned addresses and the latest top offset to aim later requests.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      last_used <= out_data.used_bytes;
      if (out_data.status == StatusOk && out_data.address != '0) begin
        seen_ptrs.push_back(out_data.address);
        if (seen_ptrs.size() > 32) void'(seen_ptrs.pop_front());
      end
    end
  end

  // Result side: segments of free flow, light and heavy stalling, and one long hold.
  initial begin : stall_pattern
    int mode;
    int seg_len;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_done = 1'b1;
      end
      mode    = $urandom_range(0, 3);
      seg_len = $urandom_range(5, 60);
      repeat (seg_len) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= 1'($urandom_range(0, 1));
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Present one request until it transfers; at the end of a burst, drop valid for a random gap.
  task automatic offer(asa_in_t item);
    int gap;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop offering and wait until every result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic asa_in_t make_item(logic [1:0] kind, logic [OffW-1:0] size,
                                        logic [3:0] align, logic [31:0] ptr,
                                        logic [OffW-1:0] mark);
    asa_in_t item;
    item.kind       = kind;
    item.alloc_size = size;
    item.align_log2 = align;
    item.pointer    = ptr;
    item.marker     = mark;
    return item;
  endfunction

  // Mostly well-formed traffic: allocations, frees of returned addresses and
  // rollbacks near the current top; unused fields carry random bits.
  function automatic asa_in_t random_request(int alloc_w);
    asa_in_t item;
    int      pick;
    item.kind       = 2'($urandom);
    item.alloc_size = OffW'($urandom);
    item.align_log2 = 4'($urandom);
    item.pointer    = $urandom;
    item.marker     = OffW'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < alloc_w) begin
      item.kind = KindAlloc;
      pick = $urandom_range(0, 99);
      if (pick < 70) item.alloc_size = OffW'($urandom_range(1, 64));
      else if (pick < 88) item.alloc_size = OffW'($urandom_range(1, 4096));
      else if (pick < 95) item.alloc_size = OffW'($urandom_range(1, (cur_cap > 1) ? cur_cap : 1));
      else if (pick < 97) item.alloc_size = '0;
      else if (pick == 97) item.alloc_size = CapLimit;
      else if (pick == 98) item.alloc_size = '1;
      if ($urandom_range(0, 19) == 0) item.align_log2 = 4'($urandom_range(13, 15));
      else item.align_log2 = 4'($urandom_range(0, MaxAlignLog2));
    end else if (pick < 85) begin
      item.kind = KindDealloc;
      pick = $urandom_range(0, 99);
      if (pick < 75 && seen_ptrs.size() > 0) begin
        if (pick < 50) item.pointer = seen_ptrs[seen_ptrs.size()-1];
        else item.pointer = seen_ptrs[$urandom_range(0, seen_ptrs.size()-1)];
      end else if (pick < 88) begin
        item.pointer = '0;
      end
    end else if (pick < 97) begin
      item.kind = KindMarker;
      pick = $urandom_range(0, 99);
      if (pick < 70) item.marker = OffW'($urandom_range(0, last_used));
      else if (pick < 85) item.marker = last_used;
    end else begin
      item.kind = KindReset;
    end
    return item;
  endfunction

  task automatic run_phase(logic [31:0] base, logic [OffW-1:0] cap, int alloc_w,
                           int count, bit with_hold);
    drain();
    write_reg(CfgBase, base);
    write_reg(CfgCap, 32'(cap));
    cur_cap    = cap;
    burst_left = 0;
    seen_ptrs.delete();
    for (int n = 0; n < count; n++) begin
      if (with_hold && n == count / 4) hold_req = 1'b1;
      offer(random_request(alloc_w));
    end
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // No region yet, then a capacity with a zero base: both must refuse.
    offer(make_item(KindAlloc, 16, 3, 0, 0));
    drain();
    write_reg(CfgCap, 32'h0001_0000);
    offer(make_item(KindAlloc, 16, 3, 0, 0));
    drain();
    write_reg(CfgBase, 32'h0000_1003);
    cur_cap = 25'h001_0000;

    // Refused sizes and alignments, then headers at byte and page alignment.
    offer(make_item(KindAlloc, 0, 2, 0, 0));
    offer(make_item(KindAlloc, 8, 13, 0, 0));
    offer(make_item(KindAlloc, 1, 0, 0, 0));
    offer(make_item(KindAlloc, 100, 12, 0, 0));
    offer(make_item(KindAlloc, 25'h1FF_FFFF, 2, 0, 0));
    offer(make_item(KindAlloc, 16, 4, 0, 0));
    offer(make_item(KindDealloc, 0, 0, 32'h0000_0000, 0));
    offer(make_item(KindDealloc, 0, 0, 32'hFFFF_FFFF, 0));
    offer(make_item(KindMarker, 0, 0, 0, 25'h1FF_FFFF));

    // Fill the record stack; the last allocation finds it full.
    repeat (14) offer(make_item(KindAlloc, 2, 1, 0, 0));
    drain();

    // Free a block in the middle of the stack, roll back further, then reset.
    offer(make_item(KindDealloc, 0, 0, seen_ptrs[5], 0));
    offer(make_item(KindMarker, 0, 0, 0, 25'd20));
    offer(make_item(KindReset, 0, 0, 0, 0));

    run_phase(32'h0000_1003, 25'h001_0000, 55, 200, 1'b0);
    run_phase(32'hFFFF_F000, 25'h1FF_FFFF, 60, 250, 1'b1);
    run_phase(32'h0000_0001, CapLimit, 50, 200, 1'b0);
    run_phase(32'hFFFF_FFFF, 25'd1, 60, 50, 1'b0);
    run_phase($urandom | 32'h1, OffW'($urandom_range(64, 8192)), 70, 250, 1'b0);
    run_phase(32'h0000_0000, '0, 50, 40, 1'b0);
    run_phase($urandom, OffW'($urandom_range(1, 1 << 24)), 45, 250, 1'b0);

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/asa_pkg.sv
rtl/core/asa_alu.sv
rtl/core/asa_rec_store.sv
rtl/core/asa_ctrl.sv
rtl/core/aligned_stack_allocator.sv
tb/aligned_stack_allocator_check.sv
tb/aligned_stack_allocator_test.sv
